// ===== rtl/pol_pkg.sv =====
// Shared types, codes and widths for the positional ordered list unit.
package pol_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned DataW       = 32;
  localparam int unsigned ActW        = 3;
  localparam int unsigned PosW        = 5;
  localparam int unsigned StatW       = 2;
  localparam int unsigned LenW        = 5;
  localparam int unsigned CapacityDef = 16;

  // Input word packing: value, then position, padded to whole bytes
  localparam int unsigned InDataW  = ((DataW + PosW + 7) / 8) * 8;
  // Output word packing: read value, then length, padded to whole bytes
  localparam int unsigned OutDataW = ((DataW + LenW + 7) / 8) * 8;

  // Action codes
  typedef enum logic [ActW-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_READ      = 3'd3,
    ACT_REMOVE    = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What the cell row does with the current word
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     rd_hit;
  } cell_cmd_t;

endpackage

// ===== rtl/positional_ordered_list_unit.sv =====
// Top level of the positional ordered list unit: ports, stages and length.
//
// Keeps an ordered list of signed 32-bit entries, up to CAPACITY of them.
// Input stream (s_axis): tuser carries the action, tdata carries the value
// and the position. Output stream (m_axis): one word per input word, with
// the read value and the new length in tdata and the status in tuser.
// An accepted word is held in the input register, and its result is
// registered in the output register when the word advances.
// Throughput: one word per cycle while the receiver takes the results;
// every action is a single pass through the decode and the cell row,
// whose cells all load in parallel.
// Reset clears the length and both stage valid flags; entry contents are
// left as they were and are never read before they are written.
// When the receiver stalls, the result stays in the output register and
// one more word is held in the input register; then s_axis_tready drops
// until the output register is taken.
module positional_ordered_list_unit #(
  parameter int unsigned CAPACITY = pol_pkg::CapacityDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pol_pkg::InDataW-1:0]  s_axis_tdata,  // value[31:0], position[36:32]
  input  logic [pol_pkg::ActW-1:0]     s_axis_tuser,  // action[2:0]
  // Output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pol_pkg::OutDataW-1:0] m_axis_tdata,  // read_value[31:0], length[36:32]
  output logic [pol_pkg::StatW-1:0]    m_axis_tuser   // status[1:0]
);
  import pol_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CntW > PosW) ? CntW : PosW;

  // Input register
  logic             in_vld_q;
  logic [ActW-1:0]  act_q;
  logic [DataW-1:0] val_q;
  logic [PosW-1:0]  pos_q;

  // List length
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;

  // Result register
  logic             out_vld_q;
  logic [DataW-1:0] rd_val_q;
  status_e          stat_q;
  logic [LenW-1:0]  len_q;

  status_e          status;
  cell_cmd_t        cmd;
  cell_cmd_t        cmd_en;
  logic [IdxW-1:0]  idx;
  logic [DataW-1:0] rd_data;
  logic             advance;
  logic             in_take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q <= s_axis_tuser;
      val_q <= s_axis_tdata[DataW-1:0];
      pos_q <= s_axis_tdata[DataW+PosW-1:DataW];
    end
  end

  pol_ctrl #(
    .Capacity (CAPACITY),
    .CntW     (CntW),
    .IdxW     (IdxW)
  ) u_ctrl (
    .act_i    (act_q),
    .pos_i    (pos_q),
    .cnt_i    (cnt_q),
    .status_o (status),
    .cnt_d_o  (cnt_d),
    .cmd_o    (cmd),
    .idx_o    (idx)
  );

  // Cells only move when the word actually advances
  always_comb begin
    cmd_en = cmd;
    if (!advance) begin
      cmd_en.op = CELL_HOLD;
    end
  end

  pol_cells #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW)
  ) u_cells (
    .clk_i     (clk_i),
    .en_i      (advance),
    .cmd_i     (cmd_en),
    .idx_i     (idx),
    .value_i   (val_q),
    .rd_data_o (rd_data)
  );

  // Length and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        cnt_q <= cnt_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_val_q <= cmd.rd_hit ? rd_data : '1;
      stat_q   <= status;
      len_q    <= LenW'(cnt_d);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - DataW - LenW){1'b0}}, len_q, rd_val_q};
  assign m_axis_tuser  = stat_q;

`ifndef NO_ASSERTIONS
  // Length never exceeds capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("list length above capacity");

  // A dropped insert reports a full list
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && stat_q == ST_FULL) |-> (len_q == LenW'(CAPACITY)))
    else $error("full status with list not full");

  // Any non-ok result carries all ones as read value
  a_err_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && stat_q != ST_OK) |-> (rd_val_q == '1))
    else $error("error result with read value");

  // Length only changes when a word moves to the output
  a_cnt_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(cnt_q))
    else $error("length changed without a word advancing");

  // Stalled input stage keeps its word
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q)
    else $error("input stage empty while not ready");
`endif

endmodule

// ===== rtl/pol_ctrl.sv =====
// Action decode: range and full checks, next length and cell row command.
module pol_ctrl #(
  parameter int unsigned Capacity = pol_pkg::CapacityDef,
  parameter int unsigned CntW     = $clog2(Capacity + 1),
  parameter int unsigned IdxW     = (CntW > pol_pkg::PosW) ? CntW : pol_pkg::PosW
) (
  input  logic [pol_pkg::ActW-1:0] act_i,
  input  logic [pol_pkg::PosW-1:0] pos_i,
  input  logic [CntW-1:0]          cnt_i,
  output pol_pkg::status_e         status_o,
  output logic [CntW-1:0]          cnt_d_o,
  output pol_pkg::cell_cmd_t       cmd_o,
  output logic [IdxW-1:0]          idx_o
);
  import pol_pkg::*;

  localparam logic [IdxW-1:0] CapIdx = IdxW'(Capacity);

  logic [IdxW-1:0] pos_ext;
  logic [IdxW-1:0] cnt_ext;
  logic            full;

  assign pos_ext = IdxW'(pos_i);
  assign cnt_ext = IdxW'(cnt_i);
  assign full    = (cnt_ext >= CapIdx);

  // Decode one action against the current length
  always_comb begin
    status_o     = ST_OK;
    cnt_d_o      = cnt_i;
    cmd_o.op     = CELL_HOLD;
    cmd_o.rd_hit = 1'b0;
    idx_o        = pos_ext;
    unique case (act_i)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
        if (act_i == ACT_INS_FRONT) begin
          idx_o = '0;
        end else if (act_i == ACT_INS_BACK) begin
          idx_o = cnt_ext;
        end
        if (idx_o > cnt_ext) begin
          status_o = ST_RANGE;
        end else if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.op = CELL_INSERT;
          cnt_d_o  = cnt_i + CntW'(1);
        end
      end
      ACT_READ: begin
        if (pos_ext < cnt_ext) begin
          cmd_o.rd_hit = 1'b1;
        end else begin
          status_o = ST_RANGE;
        end
      end
      ACT_REMOVE: begin
        if (pos_ext < cnt_ext) begin
          cmd_o.op = CELL_REMOVE;
          cnt_d_o  = cnt_i - CntW'(1);
        end else begin
          status_o = ST_RANGE;
        end
      end
      default: begin
        status_o = ST_RANGE;
      end
    endcase
  end

endmodule

// ===== rtl/pol_cells.sv =====
// Row of entry cells: each loads itself, a neighbor or the new value.
module pol_cells #(
  parameter int unsigned Capacity = pol_pkg::CapacityDef,
  parameter int unsigned IdxW     = 5
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  pol_pkg::cell_cmd_t        cmd_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic [pol_pkg::DataW-1:0] value_i,
  output logic [pol_pkg::DataW-1:0] rd_data_o
);
  import pol_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic [DataW-1:0] cell_q [Capacity];
  logic [DataW-1:0] cell_d [Capacity];

  // Per-cell next value
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    localparam logic [IdxW-1:0] MyIdx = IdxW'(i);

    always_comb begin
      cell_d[i] = cell_q[i];
      unique case (cmd_i.op)
        CELL_INSERT: begin
          if (MyIdx == idx_i) begin
            cell_d[i] = value_i;
          end else if (MyIdx > idx_i) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end
        end
        CELL_REMOVE: begin
          if ((MyIdx >= idx_i) && (i < Capacity - 1)) begin
            cell_d[i] = cell_q[(i < Capacity - 1) ? i + 1 : i];
          end
        end
        default: begin
          cell_d[i] = cell_q[i];
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  // Read port; index is below the length when the read hits
  assign rd_data_o = cell_q[idx_i[AddrW-1:0]];

endmodule
